// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge, reset included.
`define MRP_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

// Checked only outside reset.
`define MRP_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ----- design/mrp_pkg.sv -----
// Shared types and constants of the message ring producer.
`default_nettype none

package mrp_pkg;

  localparam logic        OP_PAYLOAD      = 1'b1;

  localparam logic        CFG_BUFFER_SIZE = 1'b0;
  localparam logic        CFG_RING_BASE   = 1'b1;

  localparam logic [1:0]  ST_WRITE        = 2'd0;
  localparam logic [1:0]  ST_NO_SPACE     = 2'd1;
  localparam logic [1:0]  ST_ZERO_LEN     = 2'd2;
  localparam logic [1:0]  ST_STRAY        = 2'd3;

  localparam logic [15:0] SIZE_MASK       = 16'hFFFC;
  localparam logic [15:0] SIZE_RESET      = 16'd4096;
  localparam logic [31:0] DATA_OFFSET     = 32'd8;
  localparam logic [3:0]  BE_ALL          = 4'hF;

  typedef enum logic [1:0] {
    CMD_ZERO,
    CMD_BEGIN,
    CMD_PAYLOAD
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [15:0] msg_length;
    logic [15:0] consumer_tail;
    logic [31:0] payload_word;
    logic [14:0] words;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] write_addr;
    logic [31:0] write_data;
    logic [3:0]  byte_enable;
    logic        msg_done;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

// ----- design/mrp_front.sv -----
// Front end: input beat accept, decode and a two-entry command queue.
`default_nettype none

module mrp_front (
  input  logic         clk,
  input  logic         rst,
  input  logic [63:0]  s_tdata,  // msg_length, consumer_tail, payload_word
  input  logic [0:0]   s_tuser,  // opcode
  input  logic         s_tvalid,
  output logic         s_tready,
  output mrp_pkg::cmd_t cmd,
  output logic         cmd_valid,
  input  logic         cmd_ready
);
  import mrp_pkg::*;

  cmd_t        dec;
  logic [16:0] len_sum;
  cmd_t        q [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;

  always_comb begin
    len_sum           = {1'b0, s_tdata[15:0]} + 17'd3;
    dec.msg_length    = s_tdata[15:0];
    dec.consumer_tail = s_tdata[31:16];
    dec.payload_word  = s_tdata[63:32];
    dec.words         = len_sum[16:2];
    if (s_tuser[0] == OP_PAYLOAD) begin
      dec.kind = CMD_PAYLOAD;
    end else if (s_tdata[15:0] == 16'd0) begin
      dec.kind = CMD_ZERO;
    end else begin
      dec.kind = CMD_BEGIN;
    end
  end

  assign s_tready  = (count != 2'd2);
  assign push      = s_tvalid && s_tready;
  assign cmd_valid = (count != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= dec;
    end
  end

endmodule

`default_nettype wire

// ----- design/mrp_reduce.sv -----
// Bit-serial remainder unit: re-reduces both stored offsets by a new ring size.
`default_nettype none

module mrp_reduce #(
  parameter int OFFSET_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [15:0]            divisor,
  input  logic [OFFSET_BITS-1:0] val_a,
  input  logic [OFFSET_BITS-1:0] val_b,
  output logic                   busy,
  output logic                   done,
  output logic [OFFSET_BITS-1:0] rem_a,
  output logic [OFFSET_BITS-1:0] rem_b
);
  localparam int OB = OFFSET_BITS;
  localparam int RW = 17;
  localparam int CW = $clog2(OB + 1);

  logic [OB-1:0]    sh_a;
  logic [OB-1:0]    sh_b;
  logic [RW-1:0]    ra;
  logic [RW-1:0]    rb;
  logic [RW-1:0]    ta;
  logic [RW-1:0]    tb;
  logic [RW-1:0]    ra_step;
  logic [RW-1:0]    rb_step;
  logic [RW-1:0]    dv;
  logic [CW-1:0]    cnt;
  logic [OB+RW-1:0] ra_ext;
  logic [OB+RW-1:0] rb_ext;

  always_comb begin
    dv      = {1'b0, divisor};
    ta      = {ra[RW-2:0], sh_a[OB-1]};
    tb      = {rb[RW-2:0], sh_b[OB-1]};
    ra_step = (ta >= dv) ? ta - dv : ta;
    rb_step = (tb >= dv) ? tb - dv : tb;
    ra_ext  = {{OB{1'b0}}, ra};
    rb_ext  = {{OB{1'b0}}, rb};
    rem_a   = (divisor == 16'd0) ? '0 : ra_ext[OB-1:0];
    rem_b   = (divisor == 16'd0) ? '0 : rb_ext[OB-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(OB);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_a <= val_a;
      sh_b <= val_b;
      ra   <= '0;
      rb   <= '0;
    end else if (busy) begin
      sh_a <= {sh_a[OB-2:0], 1'b0};
      sh_b <= {sh_b[OB-2:0], 1'b0};
      ra   <= ra_step;
      rb   <= rb_step;
    end
  end

endmodule

`default_nettype wire

// ----- design/mrp_back.sv -----
// Back end: ring offsets, space check, write generation and result queue.
`default_nettype none

module mrp_back #(
  parameter int OFFSET_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [15:0]      ring_size,
  input  logic [31:0]      ring_base,
  input  logic             size_wr,
  input  mrp_pkg::cmd_t    cmd,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  output mrp_pkg::result_t res,
  output logic             res_valid,
  input  logic             res_ready
);
  import mrp_pkg::*;

  localparam int OB = OFFSET_BITS;
  localparam int AW = ((OB > 16) ? OB : 16) + 2;
  localparam int QD = 4;

  // Raw offsets as last written, reduced copies as used.
  logic [OB-1:0] ph_raw, ph_raw_next;
  logic [OB-1:0] ph_red, ph_red_next;
  logic [OB-1:0] wp_raw, wp_raw_next;
  logic [OB-1:0] wp_red, wp_red_next;
  logic [14:0]   words_left, words_left_next;
  logic [1:0]    tail_bytes, tail_bytes_next;
  logic          in_msg, in_msg_next;

  logic          red_busy;
  logic          red_done;
  logic [OB-1:0] ph_fix;
  logic [OB-1:0] wp_fix;

  result_t       q [QD];
  logic [1:0]    wr_ptr;
  logic [1:0]    rd_ptr;
  logic [2:0]    count;
  logic [1:0]    n_push;
  logic          pop;
  logic          fire;
  result_t       r0;
  result_t       r1;

  logic [AW-1:0] n_w, head_w, wp_w, tail_w, pad_w, lhs, need;
  logic          room;
  logic [OB-1:0] head_step;
  logic [OB-1:0] wp_step;
  logic [31:0]   data_base;
  logic          final_word;
  logic [3:0]    be_last;

  function automatic logic [OB-1:0] wrap4(input logic [AW-1:0] v, input logic [AW-1:0] n);
    logic [AW-1:0] r;
    if (n == '0) begin
      r = '0;
    end else if (v >= n) begin
      r = v - n;
    end else begin
      r = v;
    end
    return OB'(r);
  endfunction

  mrp_reduce #(.OFFSET_BITS(OB)) u_reduce (
    .clk     (clk),
    .rst     (rst),
    .start   (size_wr),
    .divisor (ring_size),
    .val_a   (ph_raw),
    .val_b   (wp_raw),
    .busy    (red_busy),
    .done    (red_done),
    .rem_a   (ph_fix),
    .rem_b   (wp_fix)
  );

  assign cmd_ready = !red_busy && !red_done && !size_wr && (count <= 3'd2);
  assign fire      = cmd_valid && cmd_ready;
  assign res_valid = (count != 3'd0);
  assign pop       = res_valid && res_ready;
  assign res       = q[rd_ptr];

  always_comb begin
    n_w        = AW'(ring_size);
    head_w     = AW'(ph_red);
    wp_w       = AW'(wp_red);
    tail_w     = AW'(cmd.consumer_tail);
    pad_w      = AW'({cmd.words, 2'b00});
    // free = lhs - head - 4, must reach padded + 4
    lhs        = (head_w >= tail_w) ? n_w + tail_w : tail_w;
    need       = head_w + pad_w + AW'(8);
    room       = (lhs >= need);
    head_step  = wrap4(head_w + AW'(4), n_w);
    wp_step    = wrap4(wp_w + AW'(4), n_w);
    data_base  = ring_base + DATA_OFFSET;
    final_word = (words_left <= 15'd1);
    case (tail_bytes)
      2'd1:    be_last = 4'b0001;
      2'd2:    be_last = 4'b0011;
      2'd3:    be_last = 4'b0111;
      default: be_last = BE_ALL;
    endcase
  end

  always_comb begin
    ph_raw_next     = ph_raw;
    ph_red_next     = ph_red;
    wp_raw_next     = wp_raw;
    wp_red_next     = wp_red;
    words_left_next = words_left;
    tail_bytes_next = tail_bytes;
    in_msg_next     = in_msg;
    r0              = '0;
    r1              = '0;
    n_push          = 2'd0;
    if (red_done) begin
      ph_red_next = ph_fix;
      wp_red_next = wp_fix;
    end
    if (fire) begin
      n_push = 2'd1;
      case (cmd.kind)
        CMD_ZERO: begin
          in_msg_next     = 1'b0;
          words_left_next = '0;
          r0.status       = ST_ZERO_LEN;
          r0.last         = 1'b1;
        end
        CMD_BEGIN: begin
          in_msg_next     = 1'b0;
          words_left_next = '0;
          r0.last         = 1'b1;
          if (!room) begin
            r0.status = ST_NO_SPACE;
          end else begin
            r0.status       = ST_WRITE;
            r0.write_addr   = data_base + 32'(ph_red);
            r0.write_data   = 32'(cmd.msg_length);
            r0.byte_enable  = BE_ALL;
            wp_raw_next     = head_step;
            wp_red_next     = head_step;
            words_left_next = cmd.words;
            tail_bytes_next = cmd.msg_length[1:0];
            in_msg_next     = (cmd.words != 15'd0);
          end
        end
        CMD_PAYLOAD: begin
          if (!in_msg) begin
            r0.status = ST_STRAY;
            r0.last   = 1'b1;
          end else begin
            r0.status      = ST_WRITE;
            r0.write_addr  = data_base + 32'(wp_red);
            r0.write_data  = cmd.payload_word;
            r0.byte_enable = final_word ? be_last : BE_ALL;
            r0.last        = !final_word;
            wp_raw_next    = wp_step;
            wp_red_next    = wp_step;
            if (!final_word) begin
              words_left_next = words_left - 15'd1;
            end else begin
              words_left_next = '0;
              ph_raw_next     = wp_step;
              ph_red_next     = wp_step;
              in_msg_next     = 1'b0;
              r1.status       = ST_WRITE;
              r1.write_addr   = ring_base;
              r1.write_data   = 32'(wp_step);
              r1.byte_enable  = BE_ALL;
              r1.msg_done     = 1'b1;
              r1.last         = 1'b1;
              n_push          = 2'd2;
            end
          end
        end
        default: begin
          n_push = 2'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph_raw     <= '0;
      ph_red     <= '0;
      wp_raw     <= '0;
      wp_red     <= '0;
      words_left <= '0;
      tail_bytes <= '0;
      in_msg     <= 1'b0;
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      count      <= '0;
    end else begin
      ph_raw     <= ph_raw_next;
      ph_red     <= ph_red_next;
      wp_raw     <= wp_raw_next;
      wp_red     <= wp_red_next;
      words_left <= words_left_next;
      tail_bytes <= tail_bytes_next;
      in_msg     <= in_msg_next;
      wr_ptr     <= wr_ptr + n_push;
      rd_ptr     <= rd_ptr + 2'(pop);
      count      <= count + 3'(n_push) - 3'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      q[wr_ptr] <= r0;
    end
    if (n_push == 2'd2) begin
      q[wr_ptr + 2'd1] <= r1;
    end
  end

endmodule

`default_nettype wire

// ----- design/message_ring_producer.sv -----
// Top level of the message ring producer: config registers, front and back ends.
//
//   channel  dir  handshake             tdata / data                  tuser / index
//   s_       in   s_tvalid/s_tready     len, tail, payload (64b)      opcode
//   m_       out  m_tvalid/m_tready     addr, data, byte_enable (72b) status, msg_done
//   cfg_     in   cfg_valid/cfg_ready   cfg_data (32b)                cfg_index
//
// One item per cycle while the queues have room and the remainder unit is idle;
// a final payload word gives two beats, so the output port bounds the rate on
// short messages; beats wait in the command queue, results in the result queue.
// Writing buffer_size starts the bit-serial remainder unit, holding commands back.
// rst clears all offsets and queues; buffer_size resets to 4096, ring_base to 0.
// Each side stalls on its own through the command and result queues.
`default_nettype none

module message_ring_producer #(
  parameter int OFFSET_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [63:0] s_tdata,   // msg_length[15:0], consumer_tail[31:16], payload_word[63:32]
  input  logic [0:0]  s_tuser,   // opcode
  input  logic        s_tvalid,
  output logic        s_tready,
  output logic [71:0] m_tdata,   // write_addr[31:0], write_data[63:32], byte_enable[67:64]
  output logic [2:0]  m_tuser,   // status[1:0], msg_done[2]
  output logic        m_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import mrp_pkg::*;

  logic [15:0] ring_size;
  logic [31:0] ring_base;
  logic        cfg_fire;
  logic        size_wr;
  cmd_t        cmd;
  logic        cmd_valid;
  logic        cmd_ready;
  result_t     res;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign size_wr   = cfg_fire && (cfg_index[0] == CFG_BUFFER_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_size <= SIZE_RESET;
      ring_base <= '0;
    end else if (cfg_fire) begin
      case (cfg_index[0])
        CFG_BUFFER_SIZE: ring_size <= cfg_data[15:0] & SIZE_MASK;
        CFG_RING_BASE:   ring_base <= cfg_data;
        default:         ring_base <= ring_base;
      endcase
    end
  end

  mrp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready)
  );

  mrp_back #(.OFFSET_BITS(OFFSET_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .ring_size (ring_size),
    .ring_base (ring_base),
    .size_wr   (size_wr),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .res       (res),
    .res_valid (m_tvalid),
    .res_ready (m_tready)
  );

  assign m_tdata = {4'b0000, res.byte_enable, res.write_data, res.write_addr};
  assign m_tuser = {res.msg_done, res.status};
  assign m_tlast = res.last;

endmodule

`default_nettype wire

// ----- design/mrp_checker.sv -----
// Port-level checker for the message ring producer, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module mrp_checker (
  input logic        clk,
  input logic        rst,
  input logic [71:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast,
  input logic        m_tvalid,
  input logic        m_tready
);
  import mrp_pkg::*;

  `MRP_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid, "output valid right after reset")

  `MRP_ASSERT(a_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled output beat changed")

  `MRP_ASSERT(a_reject_clean, clk, rst, m_tvalid && m_tuser[1:0] != ST_WRITE |-> m_tdata == 72'd0 && !m_tuser[2] && m_tlast, "reject beat carries write fields")

  `MRP_ASSERT(a_publish_form, clk, rst, m_tvalid && m_tuser[2] |-> m_tuser[1:0] == ST_WRITE && m_tlast && m_tdata[67:64] == BE_ALL, "head publish beat malformed")

endmodule

bind message_ring_producer mrp_checker u_mrp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);

`default_nettype wire
